// ===== sv/mpd_pkg.sv =====
// Shared types and constants for the multitap pad presence decoder.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package mpd_pkg;

    // Number of pad ports handled (1 to 5)
    localparam int NUM_PORTS = 5;
    localparam int PORT_MAX  = 5;

    localparam int NIBBLE_W  = 4;
    localparam int BYTE_W    = 8;
    localparam int BTN_W     = 12;
    localparam int TIME_W    = 32;
    localparam int WINDOW_W  = 24;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_ITEM_W  = BTN_W * PORT_MAX + 3 * PORT_MAX;
    localparam int OUT_TDATA_W = ((OUT_ITEM_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0]   FLOAT_BYTE  = 8'h00;
    localparam logic [BYTE_W-1:0]   IDLE_BYTE   = 8'hFF;
    localparam logic [NIBBLE_W-1:0] NIBBLE_MASK = 4'hF;
    localparam logic [WINDOW_W-1:0] DEFAULT_WINDOW = 24'd300000;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_WINDOW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_BANK_EN     = 1'd1;

    // Configuration as seen by the lanes
    typedef struct packed {
        logic [WINDOW_W-1:0] window_us;
        logic                six_en;
    } mpd_cfg_t;

    // Per-port findings of one poll
    typedef struct packed {
        logic [BTN_W-1:0] buttons;
        logic             connected;
        logic             dropped;
        logic             ext_pad;
    } lane_res_t;

    // One result item, lowest field in the lowest bits
    typedef struct packed {
        logic [PORT_MAX-1:0]       ext_pad_mask;
        logic [PORT_MAX-1:0]       dropped_mask;
        logic [PORT_MAX-1:0]       connected_mask;
        logic [BTN_W*PORT_MAX-1:0] pressed_buttons;
    } out_item_t;

endpackage

`default_nettype wire

// ===== sv/multitap_pad_presence_decoder.sv =====
// Top level of the multitap pad presence decoder: configuration registers,
// the per-port lanes and the merge stage. Depends on mpd_pkg, mpd_port_lane
// and mpd_merge.
//
// Usage:
//   s_axis carries one finished poll per transfer; m_axis carries one result
//   per poll, in order. cfg_we/cfg_index/cfg_data write the debounce window
//   (index 0) and the extended bank enable (index 1); the user must write
//   them only while idle, not enforced by the block. Throughput: one poll
//   per cycle unless stalled; each port is decoded by its own lane and the
//   lanes update their presence state in the cycle of the transfer.
//   Reset: all ports disconnected, window 300000 us, extended bank enabled,
//   no result pending.
//   Stall: the output register is backed by a skid register, so one more
//   poll is taken while a result waits; with both full, s_axis_tready drops
//   until m_axis_tready frees a slot.
`default_nettype none

module multitap_pad_presence_decoder
    import mpd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // dpad_nibbles[19:0], action_nibbles[39:20], signature_nibbles[59:40],
    // extra_nibbles[79:60], now_us[111:80]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // pressed_buttons[59:0], connected_mask[64:60], dropped_mask[69:65],
    // ext_pad_mask[74:70], zero fill [79:75]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [WINDOW_W-1:0]    cfg_data
);

    logic [WINDOW_W-1:0] window_reg;
    logic                six_en_reg;
    mpd_cfg_t            cfg;
    logic                fire;
    logic                in_ready;
    out_item_t           out_item;
    lane_res_t [PORT_MAX-1:0] lane_res;

    logic [PORT_MAX*NIBBLE_W-1:0] dpad_nibbles;
    logic [PORT_MAX*NIBBLE_W-1:0] action_nibbles;
    logic [PORT_MAX*NIBBLE_W-1:0] signature_nibbles;
    logic [PORT_MAX*NIBBLE_W-1:0] extra_nibbles;
    logic [TIME_W-1:0]            now_us;

    // Unpack the poll
    assign dpad_nibbles      = s_axis_tdata[19:0];
    assign action_nibbles    = s_axis_tdata[39:20];
    assign signature_nibbles = s_axis_tdata[59:40];
    assign extra_nibbles     = s_axis_tdata[79:60];
    assign now_us            = s_axis_tdata[111:80];

    assign fire          = s_axis_tvalid && in_ready;
    assign s_axis_tready = in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= DEFAULT_WINDOW;
            six_en_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE_WINDOW: window_reg <= cfg_data;
                CFG_EXT_BANK_EN:     six_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg.window_us = window_reg;
    assign cfg.six_en    = six_en_reg;

    // Port lanes; ports beyond NUM_PORTS report nothing
    for (genvar p = 0; p < PORT_MAX; p++)
    begin : g_lane
        if (p < NUM_PORTS)
        begin : g_used
            mpd_port_lane u_lane (
                .clk        (clk),
                .rst_n      (rst_n),
                .fire       (fire),
                .cfg        (cfg),
                .echo_check (p != 0),
                .port0_byte ({action_nibbles[NIBBLE_W-1:0], dpad_nibbles[NIBBLE_W-1:0]}),
                .dpad       (dpad_nibbles[p*NIBBLE_W +: NIBBLE_W]),
                .action     (action_nibbles[p*NIBBLE_W +: NIBBLE_W]),
                .signature  (signature_nibbles[p*NIBBLE_W +: NIBBLE_W]),
                .extra      (extra_nibbles[p*NIBBLE_W +: NIBBLE_W]),
                .now_us     (now_us),
                .res        (lane_res[p])
            );
        end
        else
        begin : g_unused
            assign lane_res[p] = '0;
        end
    end

    // Merge and output stage
    mpd_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .lane_res  (lane_res),
        .in_ready  (in_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-OUT_ITEM_W){1'b0}}, out_item};

`ifndef SYNTHESIS
    // A port dropped on a poll is never reported connected on it
    a_drop_not_conn: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((out_item.dropped_mask & out_item.connected_mask) == '0))
        else $error("dropped port reported connected");

    // Input back-pressure only while a result is pending at the output
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // An accepted poll always leaves a result at the output next cycle
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_axis_tvalid)
        else $error("accepted poll produced no result");

    // Port 0 buttons are only reported while port 0 is connected
    a_buttons_need_conn: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !out_item.connected_mask[0])
            |-> (out_item.pressed_buttons[BTN_W-1:0] == '0))
        else $error("buttons on disconnected port");
`endif

endmodule

`default_nettype wire

// ===== sv/mpd_port_lane.sv =====
// One pad port lane: decodes the port's nibbles and keeps its presence state.
// Depends on mpd_pkg.
`default_nettype none

module mpd_port_lane
    import mpd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire mpd_cfg_t            cfg,
    input  wire logic                echo_check,
    input  wire logic [BYTE_W-1:0]   port0_byte,
    input  wire logic [NIBBLE_W-1:0] dpad,
    input  wire logic [NIBBLE_W-1:0] action,
    input  wire logic [NIBBLE_W-1:0] signature,
    input  wire logic [NIBBLE_W-1:0] extra,
    input  wire logic [TIME_W-1:0]   now_us,
    output lane_res_t                res
);

    logic              connected_reg, connected_next;
    logic              floating_seen_reg, floating_seen_next;
    logic [TIME_W-1:0] float_start_reg, float_start_next;

    logic [BYTE_W-1:0]   normal;
    logic [NIBBLE_W-1:0] ext;
    logic                six;
    logic                floating;
    logic                active;
    logic                press;
    logic                conn_pre;
    logic                fs_pre;
    logic [TIME_W-1:0]   elapsed;
    logic                drop;

    // Decode of the two scans
    always_comb
    begin
        normal   = {action, dpad};
        six      = cfg.six_en && (signature == '0) && (normal != FLOAT_BYTE);
        ext      = six ? extra : NIBBLE_MASK;
        floating = (normal == FLOAT_BYTE);
        active   = (normal != FLOAT_BYTE) && (normal != IDLE_BYTE);
        press    = active && (!echo_check || (normal != port0_byte));
    end

    // Presence update and debounced drop
    always_comb
    begin
        conn_pre         = connected_reg | press;
        fs_pre           = floating;
        float_start_next = (floating && !floating_seen_reg) ? now_us : float_start_reg;
        elapsed          = now_us - float_start_next;
        drop             = conn_pre && fs_pre &&
                           (elapsed >= {{(TIME_W-WINDOW_W){1'b0}}, cfg.window_us});
        connected_next     = conn_pre & ~drop;
        floating_seen_next = fs_pre & ~drop;
    end

    // Findings for the merge stage
    always_comb
    begin
        res.connected  = connected_next;
        res.dropped    = drop;
        res.ext_pad    = six;
        res.buttons    = (connected_next && !floating) ? {~ext, ~normal} : '0;
    end

    // Presence state, updated on each accepted poll
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            connected_reg     <= 1'b0;
            floating_seen_reg <= 1'b0;
            float_start_reg   <= '0;
        end
        else if (fire)
        begin
            connected_reg     <= connected_next;
            floating_seen_reg <= floating_seen_next;
            float_start_reg   <= float_start_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/mpd_merge.sv =====
// Merge stage: packs the lane findings into one result and holds it in an
// output register backed by a skid register. Depends on mpd_pkg.
`default_nettype none

module mpd_merge
    import mpd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   fire,
    input  wire lane_res_t [PORT_MAX-1:0] lane_res,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_item_t                   out_item
);

    out_item_t merged;
    out_item_t out_data_reg, out_data_next;
    out_item_t skid_data_reg, skid_data_next;
    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;

    // Gather lane findings
    always_comb
    begin
        merged = '0;
        for (int p = 0; p < PORT_MAX; p++)
        begin
            merged.pressed_buttons[p*BTN_W +: BTN_W] = lane_res[p].buttons;
            merged.connected_mask[p]  = lane_res[p].connected;
            merged.dropped_mask[p]    = lane_res[p].dropped;
            merged.ext_pad_mask[p]    = lane_res[p].ext_pad;
        end
    end

    // Output register and skid register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = fire;
                if (fire)
                    out_data_next = merged;
            end
        end
        else if (fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = merged;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_data_reg;

endmodule

`default_nettype wire

// ===== verif/multitap_pad_presence_decoder_test.sv =====
// Self-checking testbench for multitap_pad_presence_decoder: directed polls, then
// phases of random polls under several register settings, with random stalls.
// Depends on mpd_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module multitap_pad_presence_decoder_test;
    import mpd_pkg::*;

    localparam int LANES       = (NUM_PORTS > PORT_MAX) ? PORT_MAX : NUM_PORTS;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_POLLS = 250;

    // One poll as carried on s_axis_tdata, last field in the lowest bits
    typedef struct packed {
        logic [TIME_W-1:0]            now_us;
        logic [NIBBLE_W*PORT_MAX-1:0] extra_nibbles;
        logic [NIBBLE_W*PORT_MAX-1:0] signature_nibbles;
        logic [NIBBLE_W*PORT_MAX-1:0] action_nibbles;
        logic [NIBBLE_W*PORT_MAX-1:0] dpad_nibbles;
    } poll_t;

    // Behaviour of a port in the random polls; changes now and then
    typedef enum int {
        PORT_PRESSING,
        PORT_FLOATING,
        PORT_IDLE,
        PORT_ECHO,
        PORT_NOISE
    } port_mode_t;

    // Presence predictor and store of expected results
    class pad_scoreboard;
        logic [WINDOW_W-1:0] window_us;
        logic                six_en;
        bit                  connected[PORT_MAX];
        bit                  float_seen[PORT_MAX];
        logic [TIME_W-1:0]   float_start[PORT_MAX];
        out_item_t           expected_q[$];
        int                  errors;
        int                  results_seen;

        function new();
            window_us    = DEFAULT_WINDOW;
            six_en       = 1'b1;
            errors       = 0;
            results_seen = 0;
            for (int p = 0; p < PORT_MAX; p++)
            begin
                connected[p]   = 1'b0;
                float_seen[p]  = 1'b0;
                float_start[p] = '0;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WINDOW_W-1:0] value);
            if (idx == CFG_DEBOUNCE_WINDOW)
                window_us = value;
            else if (idx == CFG_EXT_BANK_EN)
                six_en = value[0];
        endfunction

        // Work out the result of one accepted poll and update port state
        function void note_poll(logic [IN_TDATA_W-1:0] data);
            poll_t             poll;
            logic [BYTE_W-1:0] normal[PORT_MAX];
            logic [3:0]        ext[PORT_MAX];
            bit                six[PORT_MAX];
            bit                floating;
            bit                active;
            bit                press;
            logic [TIME_W-1:0] elapsed;
            out_item_t         res;
            poll = data;
            res  = '0;
            for (int p = 0; p < LANES; p++)
            begin
                normal[p] = {poll.action_nibbles[4*p +: 4], poll.dpad_nibbles[4*p +: 4]};
                six[p]    = six_en && poll.signature_nibbles[4*p +: 4] == 4'h0 &&
                            normal[p] != FLOAT_BYTE;
                ext[p]    = six[p] ? poll.extra_nibbles[4*p +: 4] : NIBBLE_MASK;
            end
            for (int p = 0; p < LANES; p++)
            begin
                floating = (normal[p] == FLOAT_BYTE);
                active   = !floating && normal[p] != IDLE_BYTE;
                // ports past the first must not echo port 0
                press    = active && (p == 0 || normal[p] != normal[0]);
                if (press)
                    connected[p] = 1'b1;
                if (floating)
                begin
                    if (!float_seen[p])
                    begin
                        float_seen[p]  = 1'b1;
                        float_start[p] = poll.now_us;
                    end
                end
                else
                    float_seen[p] = 1'b0;
                // debounced drop, elapsed time wraps at 32 bits
                elapsed = poll.now_us - float_start[p];
                if (connected[p] && float_seen[p] && elapsed >= {8'd0, window_us})
                begin
                    connected[p]          = 1'b0;
                    float_seen[p]         = 1'b0;
                    res.dropped_mask[p]   = 1'b1;
                end
                res.ext_pad_mask[p] = six[p];
                if (connected[p])
                begin
                    res.connected_mask[p] = 1'b1;
                    if (!floating)
                        res.pressed_buttons[BTN_W*p +: BTN_W] = {~ext[p], ~normal[p]};
                end
            end
            expected_q.push_back(res);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH result %0d, %s: got %h, expected %h",
                     results_seen, what, got, want);
            errors++;
        endtask

        // Compare one accepted result with the oldest expectation
        task check_result(logic [OUT_TDATA_W-1:0] data);
            out_item_t got;
            out_item_t want;
            got = data[OUT_ITEM_W-1:0];
            if (expected_q.size() == 0)
                report("result with no poll outstanding", data[63:0], '0);
            else
            begin
                want = expected_q.pop_front();
                if (got.pressed_buttons !== want.pressed_buttons)
                    report("pressed_buttons", 64'(got.pressed_buttons),
                           64'(want.pressed_buttons));
                if (got.connected_mask !== want.connected_mask)
                    report("connected_mask", 64'(got.connected_mask),
                           64'(want.connected_mask));
                if (got.dropped_mask !== want.dropped_mask)
                    report("dropped_mask", 64'(got.dropped_mask), 64'(want.dropped_mask));
                if (got.ext_pad_mask !== want.ext_pad_mask)
                    report("ext_pad_mask", 64'(got.ext_pad_mask), 64'(want.ext_pad_mask));
                if (data[OUT_TDATA_W-1:OUT_ITEM_W] !== '0)
                    report("zero fill", 64'(data[OUT_TDATA_W-1:OUT_ITEM_W]), '0);
            end
            results_seen++;
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [WINDOW_W-1:0]    cfg_data;

    pad_scoreboard sb = new();
    int            cycle_count = 0;
    bit            steady      = 1'b0;
    bit            hold_req    = 1'b0;
    logic [TIME_W-1:0] now_t;
    port_mode_t    mode_of[PORT_MAX];

    multitap_pad_presence_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock, 10 ns period
    initial
        clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else if (r < 98)
            return $urandom_range(12, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    function automatic logic [19:0] rand_nibbles();
        logic [31:0] r;
        r = $urandom();
        return r[19:0];
    endfunction

    function automatic poll_t poll_from(logic [PORT_MAX-1:0][BYTE_W-1:0] b,
                                        logic [19:0] sig, logic [19:0] ext,
                                        logic [TIME_W-1:0] now);
        poll_t poll;
        for (int p = 0; p < PORT_MAX; p++)
        begin
            poll.dpad_nibbles[4*p +: 4]   = b[p][3:0];
            poll.action_nibbles[4*p +: 4] = b[p][7:4];
        end
        poll.signature_nibbles = sig;
        poll.extra_nibbles     = ext;
        poll.now_us            = now;
        return poll;
    endfunction

    // Offer one poll after a random gap, none when steady, and wait for its transfer
    task automatic send_poll(poll_t poll);
        int gap;
        gap = steady ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tdata  <= poll;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Stop offering and wait until every expected result has come
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WINDOW_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic set_config(logic [WINDOW_W-1:0] window, logic six);
        logic [31:0] r;
        r = $urandom();
        write_reg(CFG_DEBOUNCE_WINDOW, window);
        // upper data bits are don't-care for the enable
        write_reg(CFG_EXT_BANK_EN, {r[WINDOW_W-1:1], six});
    endtask

    // Random polls: mostly coherent per-port behaviour, some pure noise
    task automatic run_phase(int count, int hold_at);
        poll_t                           poll;
        logic [PORT_MAX-1:0][BYTE_W-1:0] b;
        logic [19:0]                     sig;
        logic [31:0]                     r;
        logic [TIME_W-1:0]               span;
        span = ({8'd0, sb.window_us} >> 2) + 32'd2;
        if ($urandom_range(1) == 1)
            now_t = 32'hFFFF_FFFF - $urandom_range(span * 8);
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_req = 1'b1;
            if ($urandom_range(99) < 12)
            begin
                poll.dpad_nibbles      = rand_nibbles();
                poll.action_nibbles    = rand_nibbles();
                poll.signature_nibbles = rand_nibbles();
                poll.extra_nibbles     = rand_nibbles();
                poll.now_us            = $urandom();
            end
            else
            begin
                for (int p = 0; p < PORT_MAX; p++)
                begin
                    if ($urandom_range(9) == 0)
                        mode_of[p] = port_mode_t'($urandom_range(4));
                    r = $urandom();
                    case (mode_of[p])
                        PORT_PRESSING: b[p] = r[7:0];
                        PORT_FLOATING: b[p] = FLOAT_BYTE;
                        PORT_IDLE:     b[p] = IDLE_BYTE;
                        PORT_ECHO:     b[p] = (p == 0) ? r[7:0] : b[0];
                        default:
                            b[p] = (r[9:8] == 2'd0) ? FLOAT_BYTE :
                                   (r[9:8] == 2'd1) ? IDLE_BYTE : r[7:0];
                    endcase
                    sig[4*p +: 4] = r[10] ? 4'h0 : r[14:11];
                end
                r = $urandom_range(99);
                if (r < 10)
                    now_t = now_t;
                else if (r < 95)
                    now_t = now_t + $urandom_range(span);
                else
                    now_t = now_t + $urandom();
                poll = poll_from(b, sig, rand_nibbles(), now_t);
            end
            send_poll(poll);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !steady && $urandom_range(99) < 30)
                stall_left = pick_gap();
            m_axis_tready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // Transfer monitor and watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_poll(s_axis_tdata);
        end
    end

    // Main sequence
    initial
    begin
        logic [TIME_W-1:0] t0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_DEBOUNCE_WINDOW;
        cfg_data      = '0;
        for (int p = 0; p < PORT_MAX; p++)
            mode_of[p] = PORT_PRESSING;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed polls at reset settings; float window crosses the time wrap
        t0 = 32'hFFFC_0000;
        send_poll(poll_from({5{FLOAT_BYTE}}, 20'h00000, 20'h00000, t0));
        send_poll(poll_from({5{IDLE_BYTE}}, 20'hFFFFF, 20'hFFFFF, t0 + 1));
        // port 0 pressed, the rest echo it
        send_poll(poll_from({5{8'h7E}}, 20'h00000, 20'h5A5A5, t0 + 2));
        send_poll(poll_from({8'h55, 8'h7F, 8'hFE, 8'h80, 8'h01}, 20'h00000, 20'h00000,
                            t0 + 3));
        send_poll(poll_from({5{FLOAT_BYTE}}, 20'h00000, 20'h00000, t0 + 10));
        send_poll(poll_from({5{FLOAT_BYTE}}, 20'h00000, 20'h00000, t0 + 10 + 299999));
        send_poll(poll_from({5{FLOAT_BYTE}}, 20'h00000, 20'h00000, t0 + 10 + 300000));
        // connected without the extended bank, then idle while connected
        send_poll(poll_from({8'hA5, 8'h3C, 8'hC3, 8'h5A, 8'h0F}, 20'hFFFFF, 20'h00000,
                            t0 + 400000));
        send_poll(poll_from({5{IDLE_BYTE}}, 20'h00000, 20'h00000, t0 + 400001));

        // zero window: floating drops on the same poll
        write_reg(CFG_DEBOUNCE_WINDOW, '0);
        send_poll(poll_from({5{FLOAT_BYTE}}, 20'h00000, 20'h00000, 32'd7));
        send_poll(poll_from({8'h11, 8'h22, 8'h33, 8'h44, 8'h0E}, 20'h00000, 20'hF0F0F,
                            32'd8));
        send_poll(poll_from({5{FLOAT_BYTE}}, 20'h00000, 20'h00000, 32'd8));

        // extended bank detection off
        write_reg(CFG_EXT_BANK_EN, 24'hFFFFFE);
        send_poll(poll_from({8'h12, 8'h34, 8'h56, 8'h78, 8'h9A}, 20'h00000, 20'h00000,
                            32'd9));

        // widest window, all input bits set, then a float that just reaches it
        write_reg(CFG_EXT_BANK_EN, 24'h000001);
        write_reg(CFG_DEBOUNCE_WINDOW, 24'hFFFFFF);
        send_poll('1);
        send_poll(poll_from({8'h01, 8'h02, 8'h04, 8'h08, 8'h10}, 20'h00000, 20'h12345,
                            32'd0));
        send_poll(poll_from({5{FLOAT_BYTE}}, 20'h00000, 20'h00000, 32'd5));
        send_poll(poll_from({5{FLOAT_BYTE}}, 20'h00000, 20'h00000, 32'd5 + 32'd16777214));
        send_poll(poll_from({5{FLOAT_BYTE}}, 20'h00000, 20'h00000, 32'd5 + 32'd16777215));
        // port 0 floating: other ports compare against a zero byte
        send_poll(poll_from({8'h66, 8'h66, 8'h66, 8'h66, FLOAT_BYTE}, 20'h00000,
                            20'hABCDE, 32'd20000000));
        // port 0 pressed; one port differs from the echoed byte
        send_poll(poll_from({8'h12, 8'h12, 8'h13, 8'h12, 8'h12}, 20'h0F0F0, 20'h00000,
                            32'd20000001));

        // Random phases over several settings
        now_t = $urandom();
        set_config(DEFAULT_WINDOW, 1'b1);
        run_phase(PHASE_POLLS, 30);
        set_config('0, 1'b1);
        run_phase(PHASE_POLLS, -1);
        set_config(24'hFFFFFF, 1'b0);
        run_phase(PHASE_POLLS, -1);
        steady = 1'b1;
        set_config(WINDOW_W'($urandom_range(5000, 1)), 1'b1);
        run_phase(PHASE_POLLS, -1);
        steady = 1'b0;
        set_config(WINDOW_W'($urandom_range(24'hFFFFFF)), 1'b1);
        run_phase(PHASE_POLLS, 100);
        set_config(24'd1, 1'b0);
        run_phase(PHASE_POLLS, -1);
        set_config(WINDOW_W'($urandom_range(100000)), 1'b1);
        run_phase(PHASE_POLLS, -1);

        // Wind down
        drain();
        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
            sb.report("results never arrived", 64'(sb.pending()), '0);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== multitap_pad_presence_decoder.f =====
sv/mpd_pkg.sv
sv/mpd_port_lane.sv
sv/mpd_merge.sv
sv/multitap_pad_presence_decoder.sv
verif/multitap_pad_presence_decoder_test.sv
